/* rtl/trs_mm_pkg.sv */
package trs_mm_pkg;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] angle_x;
        logic signed [31:0] angle_y;
        logic signed [31:0] angle_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } out_item_t;

    // one CORDIC lane: x, y in Q30 with headroom, z residual angle in Q30
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } lane_t;

    // data that rides alongside the angle lanes
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][31:0] scl;
        logic [2:0][1:0]  quad;
    } side_t;

    typedef struct packed {
        lane_t [2:0] lane;
        side_t       side;
    } cord_t;

    localparam int ATAN_ENTRIES = 30;
    localparam logic signed [33:0] ONE_Q30   = 34'sd1073741824;
    localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;
    localparam logic [26:0]        DEG2RAD_Q32 = 27'd74961321;

    localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
        30'd33543516, 30'd16775851, 30'd8388437, 30'd4194283, 30'd2097149,
        30'd1048576, 30'd524288, 30'd262144, 30'd131072, 30'd65536, 30'd32768,
        30'd16384, 30'd8192, 30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256,
        30'd128, 30'd64, 30'd32, 30'd16, 30'd8, 30'd4, 30'd2
    };

    // Q30 product, round to nearest with ties upward
    function automatic logic signed [35:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = 68'(a) * 68'(b) + 68'sd536870912;
        return p[65:30];
    endfunction

    function automatic logic signed [31:0] clamp_one(input logic signed [35:0] v);
        logic signed [35:0] lim;
        lim = 36'(ONE_Q30);
        if (v > lim)
            return 32'(lim);
        else if (v < -lim)
            return 32'(-lim);
        else
            return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -36'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage

/* rtl/trs_model_matrix.sv */
// Channel  | Handshake             | Payload
// ---------+-----------------------+--------------------------------------
// input    | in_valid / in_ready   | in_item  : position, angles, scales
// output   | out_valid / out_ready | out_item : one matrix row per item
//
// One input item gives four output items, so the block takes no new item while
// the row serialiser still holds rows of the last one to send.
// An item reaches the first row through the front stages, CORDIC cells and back stages.
// The whole pipeline moves in lockstep: it stalls only while the row holding
// register is busy and its last row is not being taken.
// Reset clears the valid bits and the row counter only; no clearing pass is needed.
module trs_model_matrix #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 20
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  trs_mm_pkg::in_item_t    in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output trs_mm_pkg::out_item_t   out_item
);
    import trs_mm_pkg::*;

    // full turn is 45 << (FRAC_BITS+3); the low bits split off, the rest is taken mod 45
    localparam int     FULL_SH = FRAC_BITS + 3;
    localparam longint FULL    = longint'(360) << FRAC_BITS;
    localparam longint KOFF    = ((longint'(1) << 31) + FULL - 1) / FULL * FULL;
    localparam int     VW      = 34 - FULL_SH;
    localparam int     RS      = VW + 6;
    localparam longint RECIP   = (longint'(1) << RS) / 45;
    localparam int     RW      = FRAC_BITS + 7;
    localparam int     ZPW     = RW + 28;

    logic en;

    // ---------------- stage 1: offset angles positive, split low bits
    logic                      s1_vld_reg;
    logic [2:0][VW-1:0]        s1_v_reg;
    logic [2:0][FULL_SH-1:0]   s1_lo_reg;
    side_t                     s1_side_reg;
    logic [2:0][31:0]          ang;
    logic [2:0][33:0]          u_next;

    assign ang = {in_item.angle_z, in_item.angle_y, in_item.angle_x};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            u_next[k] = {{2{ang[k][31]}}, ang[k]} + 34'(KOFF);
    end

    // ---------------- stage 2: quotient estimate by reciprocal
    logic                      s2_vld_reg;
    logic [2:0][VW-1:0]        s2_v_reg;
    logic [2:0][VW-1:0]        s2_qe_reg;
    logic [2:0][FULL_SH-1:0]   s2_lo_reg;
    side_t                     s2_side_reg;
    logic [2:0][VW+RS-1:0]     prod_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            prod_next[k] = (VW+RS)'(s1_v_reg[k]) * (VW+RS)'(RECIP);
    end

    // ---------------- stage 3: remainder, quadrant, angle within quadrant
    logic                      s3_vld_reg;
    logic [2:0][RW-1:0]        s3_r_reg;
    side_t                     s3_side_reg;
    logic [2:0][RW-1:0]        r_next;
    logic [2:0][1:0]           q_next;

    always_comb
    begin
        logic [VW-1:0] t;
        logic [5:0]    rem;
        logic [7:0]    w;
        logic [7:0]    rm;
        for (int k = 0; k < 3; k++)
        begin
            t   = s2_v_reg[k] - VW'(s2_qe_reg[k] * VW'(45));
            rem = (t >= VW'(45)) ? 6'(t - VW'(45)) : t[5:0];
            w   = {rem, s2_lo_reg[k][FULL_SH-1 -: 2]};
            if (w >= 8'd135)
                q_next[k] = 2'd3;
            else if (w >= 8'd90)
                q_next[k] = 2'd2;
            else if (w >= 8'd45)
                q_next[k] = 2'd1;
            else
                q_next[k] = 2'd0;
            rm = w - 8'(q_next[k] * 8'd45);
            r_next[k] = {rm[5:0], s2_lo_reg[k][FRAC_BITS:0]};
        end
    end

    // ---------------- stage 4: degrees to radians, seed the CORDIC lanes
    logic  s4_vld_reg;
    cord_t s4_reg;
    cord_t s4_next;

    always_comb
    begin
        logic [ZPW-1:0] zp;
        s4_next.side = s3_side_reg;
        for (int k = 0; k < 3; k++)
        begin
            zp = ZPW'(s3_r_reg[k]) * ZPW'(DEG2RAD_Q32)
               + (ZPW'(1) << (FRAC_BITS + 1));
            s4_next.lane[k].x = GAIN_Q30;
            s4_next.lane[k].y = '0;
            s4_next.lane[k].z = 33'(zp >> (FRAC_BITS + 2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s1_v_reg[k]  <= u_next[k][33:FULL_SH];
                s1_lo_reg[k] <= u_next[k][FULL_SH-1:0];
                s2_v_reg[k]  <= s1_v_reg[k];
                s2_qe_reg[k] <= prod_next[k][VW+RS-1:RS];
                s2_lo_reg[k] <= s1_lo_reg[k];
                s3_r_reg[k]  <= r_next[k];
            end
            s1_side_reg.pos  <= {in_item.pos_z, in_item.pos_y, in_item.pos_x};
            s1_side_reg.scl  <= {in_item.scale_z, in_item.scale_y, in_item.scale_x};
            s1_side_reg.quad <= '0;
            s2_side_reg      <= s1_side_reg;
            s3_side_reg.pos  <= s2_side_reg.pos;
            s3_side_reg.scl  <= s2_side_reg.scl;
            s3_side_reg.quad <= q_next;
            s4_reg           <= s4_next;
        end
    end

    // ---------------- chain of CORDIC cells, one rotation step per cell
    cord_t chain     [CORDIC_STEPS+1];
    logic  chain_vld [CORDIC_STEPS+1];

    assign chain[0]     = s4_reg;
    assign chain_vld[0] = s4_vld_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        trs_mm_cordic_cell #(
            .STEP (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .din_vld  (chain_vld[g]),
            .din      (chain[g]),
            .dout_vld (chain_vld[g+1]),
            .dout     (chain[g+1])
        );
    end

    cord_t c_out;
    assign c_out = chain[CORDIC_STEPS];

    // ---------------- back stage 1: clamp and fold back into the quadrant
    logic                     b1_vld_reg;
    logic signed [31:0]       b1_s_reg [3];
    logic signed [31:0]       b1_c_reg [3];
    logic [2:0][31:0]         b1_pos_reg;
    logic [2:0][31:0]         b1_scl_reg;
    logic signed [31:0]       s_next [3];
    logic signed [31:0]       c_next [3];

    always_comb
    begin
        logic signed [31:0] x;
        logic signed [31:0] y;
        for (int k = 0; k < 3; k++)
        begin
            x = clamp_one(36'(c_out.lane[k].x));
            y = clamp_one(36'(c_out.lane[k].y));
            unique case (c_out.side.quad[k])
                2'd0:
                begin
                    c_next[k] = x;
                    s_next[k] = y;
                end
                2'd1:
                begin
                    c_next[k] = -y;
                    s_next[k] = x;
                end
                2'd2:
                begin
                    c_next[k] = -x;
                    s_next[k] = -y;
                end
                default:
                begin
                    c_next[k] = y;
                    s_next[k] = -x;
                end
            endcase
        end
    end

    // ---------------- back stage 2: first products
    logic               b2_vld_reg;
    logic signed [31:0] b2_sysx_reg, b2_cysx_reg;
    logic signed [31:0] b2_cycz_reg, b2_cysz_reg, b2_sycx_reg, b2_cxsz_reg;
    logic signed [31:0] b2_cxcz_reg, b2_sycz_reg, b2_sysz_reg, b2_cycx_reg;
    logic signed [31:0] b2_sx_reg, b2_sz_reg, b2_cz_reg;
    logic [2:0][31:0]   b2_pos_reg;
    logic [2:0][31:0]   b2_scl_reg;
    logic signed [35:0] pr_next [10];

    // lane 0 is x, 1 is y, 2 is z; each product stays within one in Q30
    always_comb
    begin
        pr_next[0] = mul30(34'(b1_s_reg[1]), 34'(b1_s_reg[0]));
        pr_next[1] = mul30(34'(b1_c_reg[1]), 34'(b1_s_reg[0]));
        pr_next[2] = mul30(34'(b1_c_reg[1]), 34'(b1_c_reg[2]));
        pr_next[3] = mul30(34'(b1_c_reg[1]), 34'(b1_s_reg[2]));
        pr_next[4] = mul30(34'(b1_s_reg[1]), 34'(b1_c_reg[0]));
        pr_next[5] = mul30(34'(b1_c_reg[0]), 34'(b1_s_reg[2]));
        pr_next[6] = mul30(34'(b1_c_reg[0]), 34'(b1_c_reg[2]));
        pr_next[7] = mul30(34'(b1_s_reg[1]), 34'(b1_c_reg[2]));
        pr_next[8] = mul30(34'(b1_s_reg[1]), 34'(b1_s_reg[2]));
        pr_next[9] = mul30(34'(b1_c_reg[1]), 34'(b1_c_reg[0]));
    end

    // ---------------- back stage 3: rotation entries
    logic               b3_vld_reg;
    logic signed [31:0] b3_rot_reg [9];
    logic [2:0][31:0]   b3_pos_reg;
    logic [2:0][31:0]   b3_scl_reg;
    logic signed [31:0] rot_next [9];

    always_comb
    begin
        logic signed [35:0] t00, t01, t20, t21;
        t00 = mul30(34'(b2_sysx_reg), 34'(b2_sz_reg));
        t01 = mul30(34'(b2_sysx_reg), 34'(b2_cz_reg));
        t20 = mul30(34'(b2_cysx_reg), 34'(b2_sz_reg));
        t21 = mul30(34'(b2_cysx_reg), 34'(b2_cz_reg));
        rot_next[0] = clamp_one(36'(b2_cycz_reg) + t00);
        rot_next[1] = clamp_one(-36'(b2_cysz_reg) + t01);
        rot_next[2] = clamp_one(36'(b2_sycx_reg));
        rot_next[3] = clamp_one(36'(b2_cxsz_reg));
        rot_next[4] = clamp_one(36'(b2_cxcz_reg));
        rot_next[5] = clamp_one(-36'(b2_sx_reg));
        rot_next[6] = clamp_one(-36'(b2_sycz_reg) + t20);
        rot_next[7] = clamp_one(36'(b2_sysz_reg) + t21);
        rot_next[8] = clamp_one(36'(b2_cycx_reg));
    end

    // ---------------- back stage 4: scale, hold the matrix for the row serialiser
    logic               h_vld_reg;
    logic [1:0]         h_row_reg;
    logic signed [31:0] h_e_reg [9];
    logic [2:0][31:0]   h_pos_reg;
    logic signed [31:0] e_next [9];

    always_comb
    begin
        for (int i = 0; i < 9; i++)
            e_next[i] = sat32(mul30(34'(b3_rot_reg[i]),
                                    34'($signed(b3_scl_reg[i % 3]))));
    end

    // advance when the holding register is free or its last row leaves now
    assign en       = !h_vld_reg || (out_ready && (h_row_reg == 2'd3));
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            h_vld_reg  <= 1'b0;
            h_row_reg  <= 2'd0;
        end
        else if (en)
        begin
            b1_vld_reg <= chain_vld[CORDIC_STEPS];
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            h_vld_reg  <= b3_vld_reg;
            h_row_reg  <= 2'd0;
        end
        else if (out_ready)
        begin
            h_row_reg <= h_row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                b1_s_reg[k] <= s_next[k];
                b1_c_reg[k] <= c_next[k];
            end
            b1_pos_reg <= c_out.side.pos;
            b1_scl_reg <= c_out.side.scl;

            b2_sysx_reg <= pr_next[0][31:0];
            b2_cysx_reg <= pr_next[1][31:0];
            b2_cycz_reg <= pr_next[2][31:0];
            b2_cysz_reg <= pr_next[3][31:0];
            b2_sycx_reg <= pr_next[4][31:0];
            b2_cxsz_reg <= pr_next[5][31:0];
            b2_cxcz_reg <= pr_next[6][31:0];
            b2_sycz_reg <= pr_next[7][31:0];
            b2_sysz_reg <= pr_next[8][31:0];
            b2_cycx_reg <= pr_next[9][31:0];
            b2_sx_reg   <= b1_s_reg[0];
            b2_sz_reg   <= b1_s_reg[2];
            b2_cz_reg   <= b1_c_reg[2];
            b2_pos_reg  <= b1_pos_reg;
            b2_scl_reg  <= b1_scl_reg;

            for (int i = 0; i < 9; i++)
                b3_rot_reg[i] <= rot_next[i];
            b3_pos_reg <= b2_pos_reg;
            b3_scl_reg <= b2_scl_reg;

            for (int i = 0; i < 9; i++)
                h_e_reg[i] <= e_next[i];
            h_pos_reg <= b3_pos_reg;
        end
    end

    // ---------------- row serialiser
    assign out_valid = h_vld_reg;

    always_comb
    begin
        out_item.row_index = h_row_reg;
        unique case (h_row_reg)
            2'd0:
            begin
                out_item.col0     = h_e_reg[0];
                out_item.col1     = h_e_reg[1];
                out_item.col2     = h_e_reg[2];
                out_item.col3     = h_pos_reg[0];
                out_item.last_row = 1'b0;
            end
            2'd1:
            begin
                out_item.col0     = h_e_reg[3];
                out_item.col1     = h_e_reg[4];
                out_item.col2     = h_e_reg[5];
                out_item.col3     = h_pos_reg[1];
                out_item.last_row = 1'b0;
            end
            2'd2:
            begin
                out_item.col0     = h_e_reg[6];
                out_item.col1     = h_e_reg[7];
                out_item.col2     = h_e_reg[8];
                out_item.col3     = h_pos_reg[2];
                out_item.last_row = 1'b0;
            end
            default:
            begin
                out_item.col0     = '0;
                out_item.col1     = '0;
                out_item.col2     = '0;
                out_item.col3     = 32'(longint'(1) << FRAC_BITS);
                out_item.last_row = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/trs_mm_cordic_cell.sv */
module trs_mm_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  din_vld,
    input  trs_mm_pkg::cord_t     din,
    output logic                  dout_vld,
    output trs_mm_pkg::cord_t     dout
);
    import trs_mm_pkg::*;

    logic  vld_reg;
    cord_t data_reg;
    cord_t data_next;

    // one micro-rotation on each of the three angle lanes
    always_comb
    begin
        data_next = din;
        for (int k = 0; k < 3; k++)
        begin
            if (!din.lane[k].z[32])
            begin
                data_next.lane[k].x = din.lane[k].x - (din.lane[k].y >>> STEP);
                data_next.lane[k].y = din.lane[k].y + (din.lane[k].x >>> STEP);
                data_next.lane[k].z = din.lane[k].z - $signed({3'b000, ATAN_Q30[STEP]});
            end
            else
            begin
                data_next.lane[k].x = din.lane[k].x + (din.lane[k].y >>> STEP);
                data_next.lane[k].y = din.lane[k].y - (din.lane[k].x >>> STEP);
                data_next.lane[k].z = din.lane[k].z + $signed({3'b000, ATAN_Q30[STEP]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= din_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign dout_vld = vld_reg;
    assign dout     = data_reg;

endmodule
